/* rtl/dts_pkg.sv */
// Package for the displacement table stretch block.
// Holds request codes, register indexes, field widths, table depth, reset values and the dim_of helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dts_pkg;

    // Request codes carried in the req_type field.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 8;
    localparam int DIM_W      = 11;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 8'd3;

    // Reset values of the dimension registers.
    localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = 11'd320;
    localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = 11'd200;
    localparam logic [DIM_W-1:0] RST_DST_WIDTH  = 11'd320;
    localparam logic [DIM_W-1:0] RST_DST_HEIGHT = 11'd200;

    // Payload widths.
    localparam int ENTRY_W = 16;
    localparam int POS_W   = 10;

    // Table depth. It is a power of two, so a cell index wraps by keeping its low bits.
    localparam int MAX_CELLS = 65536;

    // A dimension register holding zero behaves as one.
    function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] reg_val);
        dim_of = (reg_val == '0) ? DIM_W'(1) : reg_val;
    endfunction

endpackage

`default_nettype wire

/* rtl/dts_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Carries a sideband word alongside each operand pair. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dts_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 11,
    parameter int TAG_W = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic      [NUM_W-1:0] o_quo,
    output logic      [DEN_W-1:0] o_rem,
    output logic      [TAG_W-1:0] o_tag
);

    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [TAG_W-1:0] r_tag [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [TAG_W-1:0] tag_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [NUM_W-1:0] n_num;
        logic [DEN_W-1:0] n_rem;

        // Stage inputs come from the ports or from the previous stage.
        if (s == 0) begin : g_first
            assign num_in = i_num;
            assign rem_in = '0;
            assign den_in = i_den;
            assign tag_in = i_tag;
        end else begin : g_next
            assign num_in = r_num[s-1];
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign tag_in = r_tag[s-1];
        end

        // Shift in one numerator bit and subtract the divisor if it fits.
        // Quotient bits fill the numerator word from the bottom.
        always_comb begin
            trial = {rem_in, num_in[NUM_W-1]};
            diff  = trial - {1'b0, den_in};
            ge    = (trial >= {1'b0, den_in});
            n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_num = {num_in[NUM_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[s] <= '0;
            end else if (i_en) begin
                r_tag[s] <= tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s] <= n_num;
                r_rem[s] <= n_rem;
                r_den[s] <= den_in;
            end
        end
    end

    assign o_quo = r_num[NUM_W-1];
    assign o_rem = r_rem[NUM_W-1];
    assign o_tag = r_tag[NUM_W-1];

endmodule

`default_nettype wire

/* rtl/dts_table.sv */
// Source displacement table: single-port synchronous memory.
// One access per cycle while enabled, read data registered. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dts_table #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16,
    parameter int DATA_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write or read; the read register holds while the pipeline stalls.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/displacement_table_stretch.sv */
// Top level of the displacement table stretch block.
// Depends on dts_pkg, dts_div and dts_table.
//
//  channel   | valid        | ready        | payload
//  ----------+--------------+--------------+---------------------------------------
//  request   | i_in_valid   | o_in_ready   | i_req_type i_entry_addr i_entry_value
//            |              |              | i_out_x i_out_y
//  result    | o_out_valid  | i_out_ready  | o_mapped_index
//  config    | i_cfg_valid  | o_cfg_ready  | i_cfg_index i_cfg_data
//
// One word is accepted per cycle while no result waits. The pipeline holds 112
// stages: the bit-per-stage dividers (cell position, target split, offset scaling,
// final wrap), the table read and the registered stages between them. Table writes
// travel the same pipeline and hit the memory in order with reads. Reset clears the
// valid bits and loads the dimension registers with their reset values; the table
// holds no reset value. When a result waits, the whole pipeline stalls. Dimension
// writes take effect at once, so they belong between bursts with nothing in flight.
`timescale 1ns / 1ps
`default_nettype none

module displacement_table_stretch (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_req_type,
    input  wire logic [dts_pkg::ENTRY_W-1:0]         i_entry_addr,
    input  wire logic [dts_pkg::ENTRY_W-1:0]         i_entry_value,
    input  wire logic [dts_pkg::POS_W-1:0]           i_out_x,
    input  wire logic [dts_pkg::POS_W-1:0]           i_out_y,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [dts_pkg::ENTRY_W-1:0]         o_mapped_index,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [dts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [dts_pkg::DIM_W-1:0]           i_cfg_data
);

    import dts_pkg::*;

    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CELL_W = 2 * DIM_W;

    typedef struct packed {
        logic               vld;
        logic               typ;
        logic [ENTRY_W-1:0] addr;
        logic [ENTRY_W-1:0] value;
    } t_req_tag;

    typedef struct packed {
        logic [POS_W-1:0] i;
        logic [POS_W-1:0] j;
    } t_pos_tag;

    typedef struct packed {
        logic               vld;
        logic               typ;
        logic [ENTRY_W-1:0] addr;
        logic [ENTRY_W-1:0] value;
        logic [POS_W-1:0]   i;
        logic [POS_W-1:0]   j;
        logic [DIM_W-1:0]   x;
        logic [DIM_W-1:0]   y;
    } t_cell_tag;

    typedef struct packed {
        logic             vld;
        logic [POS_W-1:0] i;
        logic [POS_W-1:0] j;
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
    } t_split_tag;

    typedef struct packed {
        logic             vld;
        logic [POS_W-1:0] i;
        logic [POS_W-1:0] j;
        logic             sx;
    } t_scale_tag;

    // Handshake: every stage advances unless a result is waiting.
    // Nothing is taken while reset is held.
    logic en;
    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en && i_rst_n;
    assign o_cfg_ready = i_rst_n;

    // Dimension registers.
    logic [DIM_W-1:0] r_src_w, r_src_h, r_dst_w, r_dst_h;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= RST_SRC_WIDTH;
            r_src_h <= RST_SRC_HEIGHT;
            r_dst_w <= RST_DST_WIDTH;
            r_dst_h <= RST_DST_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_h <= i_cfg_data;
                CFG_DST_WIDTH:  r_dst_w <= i_cfg_data;
                CFG_DST_HEIGHT: r_dst_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] sw, sh, dw, dh;
    assign sw = dim_of(r_src_w);
    assign sh = dim_of(r_src_h);
    assign dw = dim_of(r_dst_w);
    assign dh = dim_of(r_dst_h);

    // Frame area for the final wrap.
    logic [CELL_W-1:0] r_area;
    always_ff @(posedge i_clk) begin
        r_area <= CELL_W'(dw) * CELL_W'(dh);
    end

    // Stage 0: register the request and the cell position products.
    logic               r0_vld;
    logic               r0_typ;
    logic [ENTRY_W-1:0] r0_addr, r0_value;
    logic [POS_W-1:0]   r0_i, r0_j;
    logic [20:0]        r0_nx, r0_ny;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_in_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_typ   <= i_req_type;
            r0_addr  <= i_entry_addr;
            r0_value <= i_entry_value;
            r0_i     <= i_out_x;
            r0_j     <= i_out_y;
            r0_nx    <= 21'(i_out_x) * 21'(sw);
            r0_ny    <= 21'(i_out_y) * 21'(sh);
        end
    end

    // Nearest source column and row.
    t_req_tag   xa_tag_in, xa_tag_out;
    t_pos_tag   ya_tag_in, ya_tag_out;
    logic [20:0] xq, yq;
    logic [DIM_W-1:0] xr_unused, yr_unused;
    assign xa_tag_in = '{vld: r0_vld, typ: r0_typ, addr: r0_addr, value: r0_value};
    assign ya_tag_in = '{i: r0_i, j: r0_j};

    dts_div #(.NUM_W(21), .DEN_W(DIM_W), .TAG_W($bits(t_req_tag))) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_num(r0_nx), .i_den(dw), .i_tag(xa_tag_in),
        .o_quo(xq), .o_rem(xr_unused), .o_tag(xa_tag_out)
    );

    dts_div #(.NUM_W(21), .DEN_W(DIM_W), .TAG_W($bits(t_pos_tag))) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_num(r0_ny), .i_den(dh), .i_tag(ya_tag_in),
        .o_quo(yq), .o_rem(yr_unused), .o_tag(ya_tag_out)
    );

    // Stage 1: clamp to the last cell and form the linear cell index.
    // The index wraps into the table by keeping its low bits.
    logic [DIM_W-1:0] x1, y1;
    assign x1 = (xq >= 21'(sw)) ? (sw - DIM_W'(1)) : xq[DIM_W-1:0];
    assign y1 = (yq >= 21'(sh)) ? (sh - DIM_W'(1)) : yq[DIM_W-1:0];

    t_cell_tag     r1_tag;
    logic [AW-1:0] r1_cell;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag.vld <= 1'b0;
        end else if (en) begin
            r1_tag.vld <= xa_tag_out.vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_tag.typ   <= xa_tag_out.typ;
            r1_tag.addr  <= xa_tag_out.addr;
            r1_tag.value <= xa_tag_out.value;
            r1_tag.i     <= ya_tag_out.i;
            r1_tag.j     <= ya_tag_out.j;
            r1_tag.x     <= x1;
            r1_tag.y     <= y1;
            r1_cell      <= AW'(CELL_W'(x1) + CELL_W'(y1) * CELL_W'(sw));
        end
    end

    // Stage 2: table access, writes and reads in request order.
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [ENTRY_W-1:0] tp;
    assign mem_we   = r1_tag.vld && (r1_tag.typ == REQ_WRITE)
                      && (32'(r1_tag.addr) < 32'(MAX_CELLS));
    assign mem_addr = (r1_tag.typ == REQ_WRITE) ? AW'(r1_tag.addr) : r1_cell;

    dts_table #(.DEPTH(MAX_CELLS), .ADDR_W(AW), .DATA_W(ENTRY_W)) u_table (
        .i_clk(i_clk), .i_en(en), .i_we(mem_we),
        .i_addr(mem_addr), .i_wdata(r1_tag.value), .o_rdata(tp)
    );

    t_split_tag r2_tag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_tag.vld <= 1'b0;
        end else if (en) begin
            r2_tag.vld <= r1_tag.vld && (r1_tag.typ == REQ_QUERY);
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_tag.i <= r1_tag.i;
            r2_tag.j <= r1_tag.j;
            r2_tag.x <= r1_tag.x;
            r2_tag.y <= r1_tag.y;
        end
    end

    // Split the target into column and row.
    t_split_tag         t_tag_out;
    logic [ENTRY_W-1:0] oy;
    logic [DIM_W-1:0]   ox;
    dts_div #(.NUM_W(ENTRY_W), .DEN_W(DIM_W), .TAG_W($bits(t_split_tag))) u_div_tp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_num(tp), .i_den(sw), .i_tag(r2_tag),
        .o_quo(oy), .o_rem(ox), .o_tag(t_tag_out)
    );

    // Stage 3: offset magnitudes times the destination dimensions.
    logic signed [DIM_W:0]   ax;
    logic signed [ENTRY_W:0] ay;
    logic [DIM_W-1:0]        mag_x;
    logic [ENTRY_W-1:0]      mag_y;
    assign ax    = $signed({1'b0, ox}) - $signed({1'b0, t_tag_out.x});
    assign ay    = $signed({1'b0, oy}) - $signed((ENTRY_W+1)'(t_tag_out.y));
    assign mag_x = ax[DIM_W] ? DIM_W'(-ax) : ax[DIM_W-1:0];
    assign mag_y = ay[ENTRY_W] ? ENTRY_W'(-ay) : ay[ENTRY_W-1:0];

    t_scale_tag  r3_tag;
    logic        r3_sy;
    logic [26:0] r3_mx, r3_my;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_tag.vld <= 1'b0;
        end else if (en) begin
            r3_tag.vld <= t_tag_out.vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_tag.i  <= t_tag_out.i;
            r3_tag.j  <= t_tag_out.j;
            r3_tag.sx <= ax[DIM_W];
            r3_sy     <= ay[ENTRY_W];
            r3_mx     <= 27'(mag_x) * 27'(dw);
            r3_my     <= 27'(mag_y) * 27'(dh);
        end
    end

    // Scale the offsets to destination units.
    t_scale_tag      s_tag_out;
    logic            s_sy;
    logic [26:0]     qx, qy;
    logic [DIM_W-1:0] rx_unused, ry_unused;
    dts_div #(.NUM_W(27), .DEN_W(DIM_W), .TAG_W($bits(t_scale_tag))) u_div_dx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_num(r3_mx), .i_den(sw), .i_tag(r3_tag),
        .o_quo(qx), .o_rem(rx_unused), .o_tag(s_tag_out)
    );
    dts_div #(.NUM_W(27), .DEN_W(DIM_W), .TAG_W(1)) u_div_dy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_num(r3_my), .i_den(sh), .i_tag(r3_sy),
        .o_quo(qy), .o_rem(ry_unused), .o_tag(s_sy)
    );

    // Stage 4: apply the offset signs and add the pixel position.
    logic signed [27:0] dx, dy;
    assign dx = s_tag_out.sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    assign dy = s_sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

    logic               r4_vld;
    logic signed [28:0] r4_a, r4_s;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= s_tag_out.vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_a <= $signed(29'(s_tag_out.i)) + 29'(dx);
            r4_s <= $signed(29'(s_tag_out.j)) + 29'(dy);
        end
    end

    // Stage 5: total linear index.
    logic               r5_vld;
    logic signed [41:0] r5_tot;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_tot <= 42'(r4_s) * $signed(42'(dw)) + 42'(r4_a);
        end
    end

    // Stage 6: magnitude.
    logic        r6_vld;
    logic [40:0] r6_mag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_mag <= r5_tot[41] ? 41'(-r5_tot) : r5_tot[40:0];
        end
    end

    // Wrap into the frame; the last divider stage is the output register.
    logic [40:0]       m_quo_unused;
    logic [CELL_W-1:0] m_rem;
    dts_div #(.NUM_W(41), .DEN_W(CELL_W), .TAG_W(1)) u_div_wrap (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_num(r6_mag), .i_den(r_area), .i_tag(r6_vld),
        .o_quo(m_quo_unused), .o_rem(m_rem), .o_tag(o_out_valid)
    );

    assign o_mapped_index = m_rem[ENTRY_W-1:0];

endmodule

`default_nettype wire
